### rtl/core/process_ready_queue_macros.svh
// Assertion macros shared by the ready queue RTL.
`ifndef PROCESS_READY_QUEUE_MACROS_SVH
`define PROCESS_READY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/prq_pkg.sv
// Types, codes and defaults for the process ready queue.
package prq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_FIND   = 3'd4,
    OP_REMOVE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_MISS,
    RES_FULL,
    RES_ENTRY,
    RES_PID
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [14:0]        pid;
    logic [7:0]         prio;
    logic [3:0]         state;
    logic signed [15:0] waited_pid;
  } entry_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [14:0]        key_pid;
    logic [7:0]         entry_priority;
    logic [3:0]         entry_state;
    logic signed [15:0] entry_waited_pid;
  } prq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [14:0]        out_pid;
    logic [7:0]         out_priority;
    logic [3:0]         out_state;
    logic signed [15:0] out_waited_pid;
    logic [4:0]         occupancy;
  } prq_out_t;

  typedef struct packed {
    logic      load_req;
    logic      rd_issue;
    logic      rd_plus1;
    logic      wr_append;
    logic      wr_shift;
    logic      k_clear;
    logic      k_inc;
    logic      drop_head;
    logic      count_dec;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } prq_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       match;
    logic       more;
    logic       shift_more;
    logic       k_zero;
    logic       out_busy;
  } prq_stat_t;

endpackage

### rtl/core/prq_datapath.sv
// Queue storage, pointers, scan index and result registers.
`include "process_ready_queue_macros.svh"

module prq_datapath #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prq_pkg::prq_in_t   in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output prq_pkg::prq_out_t  out_data,
  input  prq_pkg::prq_cmd_t  cmd,
  output prq_pkg::prq_stat_t st
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  prq_pkg::entry_t   mem [QUEUE_DEPTH];
  prq_pkg::entry_t   rd_data_r;
  prq_pkg::prq_in_t  req_r;
  prq_pkg::prq_out_t res_r;
  prq_pkg::prq_out_t out_r;
  logic              out_valid_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     k_r;

  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  prq_pkg::entry_t   wr_data;
  logic              wr_en;
  logic [CW:0]       k_ext;
  prq_pkg::prq_out_t res_nxt;
  prq_pkg::prq_out_t out_nxt;

  // logical position -> physical slot, ring wraps at the depth
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                            input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign rd_idx  = k_r + AW'(cmd.rd_plus1);
  assign rd_addr = to_phys(head_r, rd_idx);
  assign wr_addr = cmd.wr_append ? to_phys(head_r, count_r[AW-1:0]) : to_phys(head_r, k_r);
  assign wr_en   = cmd.wr_append | cmd.wr_shift;

  always_comb begin
    if (cmd.wr_append) begin
      wr_data.pid        = req_r.key_pid;
      wr_data.prio       = req_r.entry_priority;
      wr_data.state      = req_r.entry_state;
      wr_data.waited_pid = req_r.entry_waited_pid;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.wr_append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.drop_head || cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.drop_head) begin
        head_r <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      if (cmd.k_clear) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  // result staging; occupancy is filled in when the output register loads
  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_kind)
      prq_pkg::RES_DONE: res_nxt.status = prq_pkg::STAT_DONE;
      prq_pkg::RES_MISS: res_nxt.status = prq_pkg::STAT_MISS;
      prq_pkg::RES_FULL: res_nxt.status = prq_pkg::STAT_FULL;
      prq_pkg::RES_ENTRY: begin
        res_nxt.status         = prq_pkg::STAT_DONE;
        res_nxt.out_pid        = rd_data_r.pid;
        res_nxt.out_priority   = rd_data_r.prio;
        res_nxt.out_state      = rd_data_r.state;
        res_nxt.out_waited_pid = rd_data_r.waited_pid;
      end
      prq_pkg::RES_PID: begin
        res_nxt.status  = prq_pkg::STAT_DONE;
        res_nxt.out_pid = rd_data_r.pid;
      end
      default: res_nxt.status = prq_pkg::STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    out_nxt           = res_r;
    out_nxt.occupancy = 5'(count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign k_ext = (CW + 1)'(k_r);

  always_comb begin
    st            = '0;
    st.op         = req_r.operation;
    st.empty      = (count_r == '0);
    st.full       = (count_r == DEPTH_C);
    st.more       = ((k_ext + (CW + 1)'(1)) < {1'b0, count_r});
    st.shift_more = ((k_ext + (CW + 1)'(2)) < {1'b0, count_r});
    st.k_zero     = (k_r == '0);
    st.out_busy   = out_valid_r & ~out_ready;
    unique case (req_r.operation)
      prq_pkg::OP_POP,
      prq_pkg::OP_PEEK:   st.match = 1'b1;
      prq_pkg::OP_LOOKUP,
      prq_pkg::OP_REMOVE: st.match = (rd_data_r.pid == req_r.key_pid);
      prq_pkg::OP_FIND:   st.match = ($unsigned(rd_data_r.waited_pid) == {1'b0, req_r.key_pid});
      default:            st.match = 1'b0;
    endcase
  end

  `PRQ_ASSERT_IMPL(a_append_room, cmd.wr_append, count_r < DEPTH_C, "append into full queue")
  `PRQ_ASSERT_IMPL(a_drop_nonempty, cmd.drop_head || cmd.count_dec, count_r != '0, "drop from empty queue")
  `PRQ_ASSERT_IMPL(a_shift_source, cmd.wr_shift, st.more, "shift source past tail")

endmodule

### rtl/core/prq_ctrl.sv
// Sequencer for append, head access, keyed scan and compaction.
`include "process_ready_queue_macros.svh"

module prq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prq_pkg::prq_stat_t st,
  output prq_pkg::prq_cmd_t  cmd
);

  prq_pkg::ctrl_state_t state_r;
  prq_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      prq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = prq_pkg::S_DISPATCH;
        end
      end
      prq_pkg::S_DISPATCH: begin
        unique case (st.op)
          prq_pkg::OP_APPEND: begin
            cmd.res_set = 1'b1;
            if (st.full) begin
              cmd.res_kind = prq_pkg::RES_FULL;
            end else begin
              cmd.res_kind  = prq_pkg::RES_DONE;
              cmd.wr_append = 1'b1;
            end
            state_nxt = prq_pkg::S_FINISH;
          end
          prq_pkg::OP_POP,
          prq_pkg::OP_PEEK,
          prq_pkg::OP_LOOKUP,
          prq_pkg::OP_FIND,
          prq_pkg::OP_REMOVE: begin
            if (st.empty) begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = prq_pkg::RES_MISS;
              state_nxt    = prq_pkg::S_FINISH;
            end else begin
              cmd.k_clear = 1'b1;
              state_nxt   = prq_pkg::S_READ;
            end
          end
          default: begin
            // undefined code: no change, plain done
            cmd.res_set  = 1'b1;
            cmd.res_kind = prq_pkg::RES_DONE;
            state_nxt    = prq_pkg::S_FINISH;
          end
        endcase
      end
      prq_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = prq_pkg::S_CMP;
      end
      prq_pkg::S_CMP: begin
        if (st.match) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = (st.op == prq_pkg::OP_FIND) ? prq_pkg::RES_PID : prq_pkg::RES_ENTRY;
          state_nxt    = prq_pkg::S_FINISH;
          if (st.op == prq_pkg::OP_POP || st.op == prq_pkg::OP_REMOVE) begin
            priority if (st.k_zero) begin
              cmd.drop_head = 1'b1;
            end else if (st.more) begin
              state_nxt = prq_pkg::S_SHIFT_RD;
            end else begin
              cmd.count_dec = 1'b1;
            end
          end
        end else if (st.more) begin
          cmd.k_inc = 1'b1;
          state_nxt = prq_pkg::S_READ;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = prq_pkg::RES_MISS;
          state_nxt    = prq_pkg::S_FINISH;
        end
      end
      prq_pkg::S_SHIFT_RD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_plus1 = 1'b1;
        state_nxt    = prq_pkg::S_SHIFT_WR;
      end
      prq_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.k_inc    = 1'b1;
        if (st.shift_more) begin
          state_nxt = prq_pkg::S_SHIFT_RD;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = prq_pkg::S_FINISH;
        end
      end
      prq_pkg::S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = prq_pkg::S_IDLE;
        end
      end
      default: state_nxt = prq_pkg::S_IDLE;
    endcase
  end

  `PRQ_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !st.out_busy, "result register overwritten")
  `PRQ_ASSERT_NEXT(a_shift_pairs, state_r == prq_pkg::S_SHIFT_RD, state_r == prq_pkg::S_SHIFT_WR, "shift read without write")
  `PRQ_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_r == prq_pkg::S_DISPATCH, "accepted request not dispatched")

endmodule

### rtl/core/process_ready_queue.sv
// Top level of the process ready queue: sequencer plus storage datapath.
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid/in_ready   | in_data  (prq_in_t)
//  out_    | result    | out_valid/out_ready | out_data (prq_out_t)
//
// Append and undefined codes go from dispatch to finish; pop/peek first read and compare the head.
// Keyed ops take one registered memory read plus one compare per entry visited.
// Remove adds a read and a write per entry moved toward the head (one read, one write port).
// in_ready is high only in idle, from the cycle after the previous result is loaded.
// Reset clears pointers, count and the FSM; storage is not cleared.
// A held result does not block the next request; its result waits until the old one leaves.
module process_ready_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prq_pkg::prq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output prq_pkg::prq_out_t out_data
);

  prq_pkg::prq_cmd_t  cmd;
  prq_pkg::prq_stat_t st;

  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

### test/process_ready_queue_tb.sv
// Self-checking testbench for the process ready queue: directed table plus random requests.
`timescale 1ns / 1ps

module process_ready_queue_tb;
  import prq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int NO_WAIT = -1;

  typedef struct {
    prq_in_t req;
    bit      preset;
    status_t preset_status;
    int      preset_occ;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  prq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  prq_out_t out_data;

  entry_t   shadow_queue[$];
  prq_out_t pending_results[$];
  dir_row_t dir_rows[$];
  int       err_count = 0;
  int       result_idx = 0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;
  bit       filling = 1'b1;

  process_ready_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [15:0] got_v, logic [15:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                result_idx, name, got_v, want_v));
  endtask

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic prq_out_t predict_queue_op(prq_in_t req);
    prq_out_t res;
    entry_t   ent;
    int       slot;
    bit       carries_entry;
    res = '0;
    res.status = STAT_DONE;
    slot = -1;
    carries_entry = 1'b0;
    case (req.operation)
      OP_APPEND: begin
        if (shadow_queue.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ent.pid = req.key_pid;
          ent.prio = req.entry_priority;
          ent.state = req.entry_state;
          ent.waited_pid = req.entry_waited_pid;
          shadow_queue.push_back(ent);
        end
      end
      OP_POP, OP_PEEK: begin
        carries_entry = 1'b1;
        if (shadow_queue.size() > 0) slot = 0;
      end
      OP_LOOKUP, OP_REMOVE: begin
        carries_entry = 1'b1;
        foreach (shadow_queue[k])
          if (slot < 0 && shadow_queue[k].pid == req.key_pid) slot = k;
      end
      OP_FIND: begin
        res.status = STAT_MISS;
        // waited_pid of -1 cannot equal a zero-extended key
        foreach (shadow_queue[k])
          if (res.status == STAT_MISS && shadow_queue[k].waited_pid == {1'b0, req.key_pid}) begin
            res.status = STAT_DONE;
            res.out_pid = shadow_queue[k].pid;
          end
      end
      default: ;
    endcase
    if (carries_entry) begin
      if (slot < 0) begin
        res.status = STAT_MISS;
      end else begin
        res.out_pid = shadow_queue[slot].pid;
        res.out_priority = shadow_queue[slot].prio;
        res.out_state = shadow_queue[slot].state;
        res.out_waited_pid = shadow_queue[slot].waited_pid;
        if (req.operation == OP_POP || req.operation == OP_REMOVE) shadow_queue.delete(slot);
      end
    end
    res.occupancy = 5'(shadow_queue.size());
    return res;
  endfunction

  function automatic logic [14:0] live_pid();
    return shadow_queue[$urandom_range(0, shadow_queue.size() - 1)].pid;
  endfunction

  // Mostly requests that hit live entries; fill and drain phases sweep the occupancy.
  function automatic prq_in_t random_request();
    prq_in_t req;
    entry_t  ent;
    int      roll;
    int      live;
    int      app_w;
    live = shadow_queue.size();
    if (live >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if (live == 0) filling = 1'b1;
    req.key_pid = 15'($urandom_range(0, 32767));
    req.entry_priority = 8'($urandom_range(0, 255));
    req.entry_state = 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 9);
    if (roll < 2) req.entry_waited_pid = 16'(NO_WAIT);
    else if (roll < 6 && live > 0) req.entry_waited_pid = {1'b0, live_pid()};
    else req.entry_waited_pid = {1'b0, 15'($urandom_range(0, 32767))};
    app_w = filling ? 55 : 15;
    roll = $urandom_range(0, app_w + 68);
    if (roll < app_w) req.operation = OP_APPEND;
    else if (roll < app_w + 12) req.operation = OP_POP;
    else if (roll < app_w + 20) req.operation = OP_PEEK;
    else if (roll < app_w + 35) req.operation = OP_LOOKUP;
    else if (roll < app_w + 50) req.operation = OP_FIND;
    else if (roll < app_w + 65) req.operation = OP_REMOVE;
    else req.operation = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
    if (live > 0 && $urandom_range(0, 3) != 0) begin
      case (req.operation)
        OP_LOOKUP, OP_REMOVE: req.key_pid = live_pid();
        OP_FIND: begin
          ent = shadow_queue[$urandom_range(0, live - 1)];
          if (ent.waited_pid >= 0) req.key_pid = ent.waited_pid[14:0];
        end
        OP_APPEND: if ($urandom_range(0, 2) == 0) req.key_pid = live_pid();
        default: ;
      endcase
    end
    return req;
  endfunction

  function automatic void add_row(logic [2:0] op, int key, int prio, int st, int waited,
                                  bit preset, status_t preset_status, int preset_occ);
    dir_row_t row;
    row.req.operation = op;
    row.req.key_pid = 15'(key);
    row.req.entry_priority = 8'(prio);
    row.req.entry_state = 4'(st);
    row.req.entry_waited_pid = 16'(waited);
    row.preset = preset;
    row.preset_status = preset_status;
    row.preset_occ = preset_occ;
    dir_rows.push_back(row);
  endfunction

  task automatic send_request(prq_in_t req, bit preset, status_t preset_status, int preset_occ);
    int       gap;
    prq_out_t want;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = predict_queue_op(req);
    if (preset) begin
      want = '0;
      want.status = preset_status;
      want.occupancy = 5'(preset_occ);
    end
    pending_results.push_back(want);
  endtask

  task automatic check_result(prq_out_t got);
    prq_out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request pending", result_idx));
    end else begin
      want = pending_results.pop_front();
      check_field("status", 16'(got.status), 16'(want.status));
      check_field("pid", 16'(got.out_pid), 16'(want.out_pid));
      check_field("priority", 16'(got.out_priority), 16'(want.out_priority));
      check_field("state", 16'(got.out_state), 16'(want.out_state));
      check_field("waited_pid", got.out_waited_pid, want.out_waited_pid);
      check_field("occupancy", 16'(got.occupancy), 16'(want.occupancy));
    end
    result_idx++;
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result(out_data);
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // every op on an empty queue, then fill to full with a duplicate pid and apply the ops again
    add_row(OP_POP, 0, 0, 0, 0, 1, STAT_MISS, 0);
    add_row(OP_PEEK, 32767, 255, 15, 32767, 1, STAT_MISS, 0);
    add_row(OP_LOOKUP, 0, 0, 0, NO_WAIT, 1, STAT_MISS, 0);
    add_row(OP_FIND, 32767, 0, 0, 0, 1, STAT_MISS, 0);
    add_row(OP_REMOVE, 32767, 0, 0, 0, 1, STAT_MISS, 0);
    add_row(OP_RSVD6, 0, 0, 0, 0, 1, STAT_DONE, 0);
    add_row(OP_APPEND, 32767, 255, 15, 32767, 0, STAT_DONE, 0);
    add_row(OP_APPEND, 0, 0, 0, NO_WAIT, 0, STAT_DONE, 0);
    add_row(OP_FIND, 32767, 0, 0, 0, 0, STAT_DONE, 0);
    for (int i = 1; i <= DEPTH - 2; i++)
      add_row(OP_APPEND, (i == 6) ? 0 : (i * 2341) % 32768, (i * 37) % 256, i % 16,
              (i == 4) ? 0 : i - 1, 0, STAT_DONE, 0);
    add_row(OP_APPEND, 12345, 1, 1, 1, 1, STAT_FULL, DEPTH);
    add_row(OP_RSVD7, 0, 0, 0, 0, 1, STAT_DONE, DEPTH);
    add_row(OP_LOOKUP, 0, 0, 0, 0, 0, STAT_DONE, 0);
    add_row(OP_FIND, 0, 0, 0, 0, 0, STAT_DONE, 0);
    add_row(OP_REMOVE, 3 * 2341, 0, 0, 0, 0, STAT_DONE, 0);
    add_row(OP_POP, 0, 0, 0, 0, 0, STAT_DONE, 0);
    add_row(OP_PEEK, 0, 0, 0, 0, 0, STAT_DONE, 0);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].preset, dir_rows[i].preset_status,
                   dir_rows[i].preset_occ);
    repeat (RANDOM_REQUESTS) send_request(random_request(), 1'b0, STAT_DONE, 0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
